FILE: rtl/sbfc_pkg.sv
// sbfc_pkg: shared constants, codes and helpers for the seven-bit frame codec.
// Used by seven_bit_frame_codec; no dependencies.
package sbfc_pkg;

    localparam int STORE_DEPTH = 17;
    localparam int CNT_W       = 5;
    localparam int ADDR_W      = 5;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CHECK = 2'd1,
        ST_LONG  = 2'd2,
        ST_SHORT = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION  = 3'd0,
        CFG_ENC_PACK   = 3'd1,
        CFG_ENC_CHECK  = 3'd2,
        CFG_DEC_PACK   = 3'd3,
        CFG_DEC_CHECK  = 3'd4
    } cfg_index_t;

    // Byte position split into trailer byte (q) and bit within it (r).
    typedef struct packed {
        logic [2:0] q;
        logic [2:0] r;
    } split7_t;

    // Quotient and remainder by seven for a small count.
    function automatic split7_t split7(input logic [CNT_W-1:0] v);
        split7_t s;
        if (v < CNT_W'(7)) begin
            s.q = 3'd0;
            s.r = 3'(v);
        end else if (v < CNT_W'(14)) begin
            s.q = 3'd1;
            s.r = 3'(v - CNT_W'(7));
        end else if (v < CNT_W'(21)) begin
            s.q = 3'd2;
            s.r = 3'(v - CNT_W'(14));
        end else if (v < CNT_W'(28)) begin
            s.q = 3'd3;
            s.r = 3'(v - CNT_W'(21));
        end else begin
            s.q = 3'd4;
            s.r = 3'(v - CNT_W'(28));
        end
        return s;
    endfunction

endpackage

FILE: rtl/seven_bit_frame_codec.sv
// seven_bit_frame_codec: frames bytes for a 7-bit serial link (encode and decode).
// Depends on sbfc_pkg and sbfc_ram (17-entry frame store).
//
// Usage
//   s_axis carries one frame byte per word (tdata) with tlast on the frame's
//   last byte. m_axis returns result words: tdata is the byte, tuser carries
//   the byte-valid flag and the frame status, tlast marks a frame's final word.
//   cfg_* writes one 1-bit register per word (index 0..4); write only while idle.
// Encode: each byte accepted within capacity gives its result word in the next
//   cycle, one byte per cycle while m_axis keeps up. At frame end the TRAILER_BYTES
//   trailer bytes (when packing) and the checksum (when enabled) follow at one
//   word per cycle while m_axis keeps up; no input is taken during that burst.
// Decode: bytes go into the frame store at one per cycle with no output. At
//   frame end the sequencer reads the trailer bytes and the checksum byte, each
//   when enabled (one RAM read per cycle), then streams the payload at one
//   word per cycle. The RAM read port sets this pace.
// Stall: results sit in an output register; while it is full and not taken,
//   the sequencer and the input hold. RAM read data holds during the stall.
// Reset: registers return to their defaults and frame state clears. The frame
//   store is not cleared; every entry read for a frame was written first.
module seven_bit_frame_codec #(
    parameter int TRAILER_BYTES = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,  // frame_end
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] out_byte
    output logic                            m_axis_tlast,  // out_last
    output logic [2:0]                      m_axis_tuser,  // [0] byte_valid, [2:1] status
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data
);

    import sbfc_pkg::*;

    localparam int TIW = (TRAILER_BYTES > 1) ? $clog2(TRAILER_BYTES) : 1;
    localparam logic [TIW-1:0]   T_LAST   = TIW'(TRAILER_BYTES - 1);
    localparam logic [CNT_W-1:0] T_CNT    = CNT_W'(TRAILER_BYTES);
    localparam logic [CNT_W-1:0] CAP_PACK = CNT_W'(7 * TRAILER_BYTES);
    localparam logic [CNT_W-1:0] CAP_RAW  = CNT_W'(STORE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENC_TRL,
        S_ENC_CHK,
        S_DEC_TRL,
        S_DEC_CHK,
        S_DEC_PAY,
        S_DEC_FIN
    } state_t;

    // What the RAM read data of this cycle belongs to.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_TRL,
        RD_CHK,
        RD_PAY
    } rd_kind_t;

    // configuration
    logic direction_reg, direction_next;
    logic enc_pack_reg, enc_pack_next;
    logic enc_chk_reg, enc_chk_next;
    logic dec_pack_reg, dec_pack_next;
    logic dec_chk_reg, dec_chk_next;

    // frame state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [6:0]       sum_reg, sum_next;
    logic [6:0]       trailer_reg [TRAILER_BYTES];
    logic [6:0]       trailer_next [TRAILER_BYTES];
    logic             overflow_reg, overflow_next;
    logic [TIW-1:0]   t_reg, t_next;
    logic [CNT_W-1:0] p_reg, p_next;
    logic [7:0]       chk_reg, chk_next;
    rd_kind_t         rd_kind_reg, rd_kind_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_bv_reg, out_bv_next;
    logic             out_last_reg, out_last_next;
    status_t          out_status_reg, out_status_next;

    // RAM port
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    // datapath helpers
    logic             out_free;
    logic             s_accept;
    logic [CNT_W-1:0] enc_cap;
    logic             enc_emit;
    logic [7:0]       enc_byte;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] cnt_n;
    logic [CNT_W-1:0] np;
    split7_t          sp_enc;
    split7_t          sp_dec;
    logic             pay_top;
    logic [7:0]       pay_byte;
    logic [6:0]       pay_sum;
    logic             issue;
    logic             emit;
    logic             load_out;
    logic [7:0]       ld_data;
    logic             ld_bv;
    logic             ld_last;
    status_t          ld_status;
    logic             clear_frame;

    sbfc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_status_reg, out_bv_reg};

    // Encode: capacity, emitted byte, trailer bit position.
    assign enc_cap  = enc_pack_reg ? CAP_PACK : CAP_RAW;
    assign enc_emit = byte_count_reg < enc_cap;
    assign sp_enc   = split7(byte_count_reg);
    always_comb
    begin
        enc_byte = s_axis_tdata;
        if (enc_pack_reg)
        begin
            enc_byte = (byte_count_reg == '0) ? (s_axis_tdata | 8'h80)
                                              : (s_axis_tdata & 8'h7F);
        end
    end

    // Decode: bytes needed for check/trailers, payload length, restored byte.
    assign need = (dec_chk_reg ? CNT_W'(1) : '0) + (dec_pack_reg ? T_CNT : '0);
    assign np   = byte_count_reg - (dec_chk_reg ? CNT_W'(1) : '0)
                - (dec_pack_reg ? T_CNT : '0);
    assign sp_dec  = split7(rd_idx_reg);
    assign pay_top = dec_pack_reg && (int'(sp_dec.q) < TRAILER_BYTES)
                     && trailer_reg[sp_dec.q[TIW-1:0]][sp_dec.r];
    assign pay_byte = {pay_top, ram_rd_data[6:0]};
    assign pay_sum  = sum_reg + ram_rd_data[6:0];

    always_comb
    begin
        direction_next  = direction_reg;
        enc_pack_next   = enc_pack_reg;
        enc_chk_next    = enc_chk_reg;
        dec_pack_next   = dec_pack_reg;
        dec_chk_next    = dec_chk_reg;
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        trailer_next    = trailer_reg;
        overflow_next   = overflow_reg;
        t_next          = t_reg;
        p_next          = p_reg;
        chk_next        = chk_reg;
        rd_kind_next    = RD_NONE;
        rd_idx_next     = rd_idx_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = byte_count_reg;
        ram_wr_data     = s_axis_tdata;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        cnt_n           = byte_count_reg;
        issue           = 1'b0;
        emit            = 1'b0;
        load_out        = 1'b0;
        ld_data         = '0;
        ld_bv           = 1'b0;
        ld_last         = 1'b0;
        ld_status       = ST_OK;
        clear_frame     = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DIRECTION: direction_next = cfg_data;
                CFG_ENC_PACK:  enc_pack_next  = cfg_data;
                CFG_ENC_CHECK: enc_chk_next   = cfg_data;
                CFG_DEC_PACK:  dec_pack_next  = cfg_data;
                CFG_DEC_CHECK: dec_chk_next   = cfg_data;
                default: ;
            endcase
        end

        // Capture trailer and checksum reads in the cycle after issue.
        if (rd_kind_reg == RD_TRL)
        begin
            trailer_next[rd_idx_reg[TIW-1:0]] = ram_rd_data[6:0];
            sum_next = sum_reg + ram_rd_data[6:0];
        end
        if (rd_kind_reg == RD_CHK)
        begin
            chk_next = ram_rd_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && !direction_reg)
                begin
                    if (enc_emit)
                    begin
                        if (enc_pack_reg)
                        begin
                            trailer_next[sp_enc.q[TIW-1:0]][sp_enc.r] =
                                trailer_reg[sp_enc.q[TIW-1:0]][sp_enc.r] | s_axis_tdata[7];
                        end
                        sum_next        = sum_reg + enc_byte[6:0];
                        byte_count_next = byte_count_reg + CNT_W'(1);
                        load_out        = 1'b1;
                        ld_data         = enc_byte;
                        ld_bv           = 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        t_next = '0;
                        if (enc_pack_reg)
                        begin
                            state_next = S_ENC_TRL;
                        end
                        else if (enc_chk_reg)
                        begin
                            state_next = S_ENC_CHK;
                        end
                        else
                        begin
                            // nothing follows: this word (or a status-only word) ends the frame
                            load_out    = 1'b1;
                            ld_last     = 1'b1;
                            ld_status   = overflow_next ? ST_LONG : ST_OK;
                            clear_frame = 1'b1;
                        end
                    end
                end
                else if (s_accept)
                begin
                    if (byte_count_reg < CAP_RAW)
                    begin
                        ram_wr_en       = 1'b1;
                        cnt_n           = byte_count_reg + CNT_W'(1);
                        byte_count_next = cnt_n;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        if (overflow_next)
                        begin
                            load_out    = 1'b1;
                            ld_last     = 1'b1;
                            ld_status   = ST_LONG;
                            clear_frame = 1'b1;
                        end
                        else if (cnt_n < need)
                        begin
                            load_out    = 1'b1;
                            ld_last     = 1'b1;
                            ld_status   = ST_SHORT;
                            clear_frame = 1'b1;
                        end
                        else
                        begin
                            // keep the count for the read sequence; reuse sum and trailers
                            sum_next = '0;
                            for (int i = 0; i < TRAILER_BYTES; i++)
                            begin
                                trailer_next[i] = '0;
                            end
                            t_next = '0;
                            p_next = '0;
                            if (dec_pack_reg)
                            begin
                                state_next = S_DEC_TRL;
                            end
                            else if (dec_chk_reg)
                            begin
                                state_next = S_DEC_CHK;
                            end
                            else
                            begin
                                state_next = S_DEC_PAY;
                            end
                        end
                    end
                end
            end

            S_ENC_TRL:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    ld_data  = {1'b0, trailer_reg[t_reg]};
                    ld_bv    = 1'b1;
                    sum_next = sum_reg + trailer_reg[t_reg];
                    if (t_reg == T_LAST)
                    begin
                        if (enc_chk_reg)
                        begin
                            state_next = S_ENC_CHK;
                        end
                        else
                        begin
                            ld_last     = 1'b1;
                            ld_status   = overflow_reg ? ST_LONG : ST_OK;
                            clear_frame = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        t_next = t_reg + TIW'(1);
                    end
                end
            end

            S_ENC_CHK:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    ld_data     = {1'b0, sum_reg};
                    ld_bv       = 1'b1;
                    ld_last     = 1'b1;
                    ld_status   = overflow_reg ? ST_LONG : ST_OK;
                    clear_frame = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_DEC_TRL:
            begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = np + CNT_W'(t_reg);
                rd_kind_next = RD_TRL;
                rd_idx_next  = CNT_W'(t_reg);
                if (t_reg == T_LAST)
                begin
                    if (dec_chk_reg)
                    begin
                        state_next = S_DEC_CHK;
                    end
                    else
                    begin
                        state_next = (np == '0) ? S_DEC_FIN : S_DEC_PAY;
                    end
                end
                else
                begin
                    t_next = t_reg + TIW'(1);
                end
            end

            S_DEC_CHK:
            begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = byte_count_reg - CNT_W'(1);
                rd_kind_next = RD_CHK;
                state_next   = (np == '0) ? S_DEC_FIN : S_DEC_PAY;
            end

            S_DEC_PAY:
            begin
                emit  = (rd_kind_reg == RD_PAY) && out_free;
                issue = (p_reg < np) && ((rd_kind_reg != RD_PAY) || out_free);
                if (issue)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = p_reg;
                    rd_kind_next = RD_PAY;
                    rd_idx_next  = p_reg;
                    p_next       = p_reg + CNT_W'(1);
                end
                else if ((rd_kind_reg == RD_PAY) && !out_free)
                begin
                    // hold the read data until the output register frees
                    rd_kind_next = RD_PAY;
                end
                if (emit)
                begin
                    load_out = 1'b1;
                    ld_data  = pay_byte;
                    ld_bv    = 1'b1;
                    sum_next = pay_sum;
                    if (rd_idx_reg == np - CNT_W'(1))
                    begin
                        ld_last = 1'b1;
                        if (dec_chk_reg && (chk_reg != {1'b0, pay_sum}))
                        begin
                            ld_status = ST_CHECK;
                        end
                        clear_frame = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_DEC_FIN:
            begin
                // empty payload: wait for the last capture, then report status only
                if ((rd_kind_reg == RD_NONE) && out_free)
                begin
                    load_out = 1'b1;
                    ld_last  = 1'b1;
                    if (dec_chk_reg && (chk_reg != {1'b0, sum_reg}))
                    begin
                        ld_status = ST_CHECK;
                    end
                    clear_frame = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear_frame)
        begin
            byte_count_next = '0;
            sum_next        = '0;
            overflow_next   = 1'b0;
            for (int i = 0; i < TRAILER_BYTES; i++)
            begin
                trailer_next[i] = '0;
            end
        end

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_bv_next     = out_bv_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = ld_data;
            out_bv_next     = ld_bv;
            out_last_next   = ld_last;
            out_status_next = ld_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= 1'b0;
            enc_pack_reg   <= 1'b1;
            enc_chk_reg    <= 1'b1;
            dec_pack_reg   <= 1'b0;
            dec_chk_reg    <= 1'b1;
            state_reg      <= S_IDLE;
            byte_count_reg <= '0;
            sum_reg        <= '0;
            for (int i = 0; i < TRAILER_BYTES; i++)
            begin
                trailer_reg[i] <= '0;
            end
            overflow_reg   <= 1'b0;
            t_reg          <= '0;
            p_reg          <= '0;
            chk_reg        <= '0;
            rd_kind_reg    <= RD_NONE;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_bv_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            direction_reg  <= direction_next;
            enc_pack_reg   <= enc_pack_next;
            enc_chk_reg    <= enc_chk_next;
            dec_pack_reg   <= dec_pack_next;
            dec_chk_reg    <= dec_chk_next;
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            trailer_reg    <= trailer_next;
            overflow_reg   <= overflow_next;
            t_reg          <= t_next;
            p_reg          <= p_next;
            chk_reg        <= chk_next;
            rd_kind_reg    <= rd_kind_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_bv_reg     <= out_bv_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

    // Payload read data only exists while streaming the payload.
    a_pay_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_kind_reg == RD_PAY) |-> (state_reg == S_DEC_PAY))
        else $error("payload read outside payload stream");

    // A stalled payload word keeps its RAM data.
    a_pay_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((rd_kind_reg == RD_PAY) && !out_free) |=> $stable(ram_rd_data))
        else $error("RAM data changed under a stalled payload word");

    // Status is reported on the final word of a frame only.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == ST_OK))
        else $error("status on a word that is not the last");

    // A status-only word always ends its frame.
    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("status-only word without tlast");

    // The decode sequence never addresses beyond the frame store.
    a_dec_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DEC_TRL) || (state_reg == S_DEC_CHK)
            || (state_reg == S_DEC_PAY) || (state_reg == S_DEC_FIN))
        |-> (byte_count_reg <= CAP_RAW))
        else $error("decode count beyond frame store");

endmodule

FILE: rtl/sbfc_ram.sv
// sbfc_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies; contents are undefined until written.
module sbfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 17
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
